// ===== rtl/motion_intent_scorer_unit_assert.svh =====
// assertion macros for the motion intent scorer
// expects clk_i and rst_ni in the scope of the module that expands them
`ifndef MOTION_INTENT_SCORER_UNIT_ASSERT_SVH
`define MOTION_INTENT_SCORER_UNIT_ASSERT_SVH

// same-cycle implication
`define MIS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("motion_intent_scorer_unit: assertion failed");

// next-cycle implication
`define MIS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("motion_intent_scorer_unit: assertion failed");

`endif

// ===== rtl/mis_pkg.sv =====
// shared types, constants and weight table of the motion intent scorer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mis_pkg;

  localparam int FEAT_W     = 24;
  localparam int DIFF_W     = FEAT_W + 1;
  localparam int SPAN_W     = FEAT_W;
  localparam int QUO_W      = 16;
  localparam int SCORE_W    = QUO_W + 1;
  localparam int CNT_W      = 4;
  localparam int FEAT_IDX_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int WEIGHT_W   = 15;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = PROD_W + 1;
  localparam int MIX_W      = 2 * SCORE_W;

  localparam logic [SCORE_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [SCORE_W-1:0] ALPHA   = 17'd16384;
  localparam logic [SCORE_W-1:0] KEEP    = ONE_Q16 - ALPHA;

  localparam logic [CNT_W-1:0]      DIV_LAST  = CNT_W'(QUO_W - 1);
  localparam logic [FEAT_IDX_W-1:0] FEAT_LAST = 2'd3;

  localparam logic [FEAT_IDX_W-1:0] FEAT_SPREAD    = 2'd0;
  localparam logic [FEAT_IDX_W-1:0] FEAT_VELOCITY  = 2'd1;
  localparam logic [FEAT_IDX_W-1:0] FEAT_AMPLITUDE = 2'd2;
  localparam logic [FEAT_IDX_W-1:0] FEAT_FREQUENCY = 2'd3;

  typedef struct packed {
    logic signed [FEAT_W-1:0] spread;
    logic signed [FEAT_W-1:0] phase_velocity;
    logic signed [FEAT_W-1:0] amplitude;
    logic signed [FEAT_W-1:0] frequency;
  } mis_in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] conf;
    logic [SCORE_W-1:0] halt;
  } mis_out_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] low;
    logic signed [FEAT_W-1:0] high;
  } mis_thr_t;

  typedef struct packed {
    logic               vld;
    logic [SCORE_W-1:0] score;
  } mis_score_rsp_t;

  typedef struct packed {
    logic               vld;
    logic [SCORE_W-1:0] conf;
  } mis_blend_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_DRAIN
  } mis_state_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_PREP,
    SC_DIV
  } mis_sc_state_e;

  localparam mis_thr_t THR_RESET [4] = '{
    '{low: 24'sd0, high: 24'sd40960},
    '{low: 24'sd0, high: 24'sd409600},
    '{low: 24'sd0, high: 24'sd2048},
    '{low: 24'sd0, high: 24'sd4096}
  };

  // q0.16 weights 0.35 / 0.30 / 0.20 / 0.15, summing to one
  function automatic logic [WEIGHT_W-1:0] weight(input logic [FEAT_IDX_W-1:0] k);
    logic [WEIGHT_W-1:0] w;
    unique case (k)
      FEAT_SPREAD:    w = 15'd22938;
      FEAT_VELOCITY:  w = 15'd19661;
      FEAT_AMPLITUDE: w = 15'd13107;
      FEAT_FREQUENCY: w = 15'd9830;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/motion_intent_scorer_unit.sv =====
// motion intent scorer: how much a gait looks like active motion
//
// in channel: in_valid_i / in_stall_o carry one item of four signed q12.12
// gait features. out channel: out_valid_o / out_stall_i carry the smoothed
// confidence and one minus it, both q1.16 with 65536 as one. the user must
// write thresholds via cfg_we_i / cfg_idx_i / cfg_data_i only while idle;
// the block itself does not enforce it.
// one item at a time: the four features are scored in turn by one shared
// unit whose restoring divider yields one quotient bit per cycle. a feature
// ends after the threshold compare when it saturates or its thresholds are
// degenerate, else it goes on through the divider; blending and smoothing
// follow, and the next item is accepted only once this one has finished.
// in_stall_o is high from accept until the result moves into the output
// register, so the next item is taken while the last result still waits.
// a stalled receiver holds out_valid_o and the payload; once a second
// result is ready it also holds the block busy.
// reset clears the thresholds to their defaults and the average to zero.
// depends on mis_pkg, mis_score_unit, mis_blend and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "motion_intent_scorer_unit_assert.svh"

module motion_intent_scorer_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [mis_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [mis_pkg::FEAT_W-1:0]            cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire mis_pkg::mis_in_t                      in_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output mis_pkg::mis_out_t                          out_data_o
);

  mis_pkg::mis_state_e state_q, state_d;
  logic [mis_pkg::FEAT_IDX_W-1:0] feat_q, feat_d;
  mis_pkg::mis_in_t item_q;
  mis_pkg::mis_thr_t thr_q [4];
  logic out_vld_q, out_vld_d;
  mis_pkg::mis_out_t out_data_q, out_data_d;

  logic in_acc;
  logic sc_start;
  logic bl_take;
  logic signed [mis_pkg::FEAT_W-1:0] feat_val;
  mis_pkg::mis_score_rsp_t sc_rsp;
  mis_pkg::mis_blend_rsp_t bl_rsp;

  assign in_stall_o = (state_q != mis_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    unique case (feat_q)
      mis_pkg::FEAT_SPREAD:    feat_val = item_q.spread;
      mis_pkg::FEAT_VELOCITY:  feat_val = item_q.phase_velocity;
      mis_pkg::FEAT_AMPLITUDE: feat_val = item_q.amplitude;
      default:                 feat_val = item_q.frequency;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    feat_d     = feat_q;
    sc_start   = 1'b0;
    bl_take    = 1'b0;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      mis_pkg::ST_IDLE: begin
        if (in_acc) begin
          feat_d  = mis_pkg::FEAT_SPREAD;
          state_d = mis_pkg::ST_LAUNCH;
        end
      end
      mis_pkg::ST_LAUNCH: begin
        sc_start = 1'b1;
        state_d  = mis_pkg::ST_WAIT;
      end
      mis_pkg::ST_WAIT: begin
        if (sc_rsp.vld) begin
          if (feat_q == mis_pkg::FEAT_LAST) begin
            state_d = mis_pkg::ST_DRAIN;
          end else begin
            feat_d  = feat_q + 1'b1;
            state_d = mis_pkg::ST_LAUNCH;
          end
        end
      end
      mis_pkg::ST_DRAIN: begin
        // output register free or emptying this cycle
        if (bl_rsp.vld && (!out_vld_q || !out_stall_i)) begin
          bl_take    = 1'b1;
          out_vld_d  = 1'b1;
          out_data_d = '{conf: bl_rsp.conf,
                         halt: mis_pkg::ONE_Q16 - bl_rsp.conf};
          state_d    = mis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mis_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mis_pkg::ST_IDLE;
      feat_q    <= '0;
      out_vld_q <= 1'b0;
      thr_q     <= mis_pkg::THR_RESET;
    end else begin
      state_q   <= state_d;
      feat_q    <= feat_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        if (cfg_idx_i[0]) begin
          thr_q[cfg_idx_i[mis_pkg::CFG_IDX_W-1:1]].high <= cfg_data_i;
        end else begin
          thr_q[cfg_idx_i[mis_pkg::CFG_IDX_W-1:1]].low <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_acc) begin
      item_q <= in_data_i;
    end
  end

  mis_score_unit u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start),
    .value_i (feat_val),
    .thr_i   (thr_q[feat_q]),
    .rsp_o   (sc_rsp)
  );

  mis_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (in_acc),
    .score_i (sc_rsp),
    .sel_i   (feat_q),
    .take_i  (bl_take),
    .rsp_o   (bl_rsp)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  `MIS_ASSERT_IMPL(a_sum_one, out_vld_q, (out_data_q.conf + out_data_q.halt) == mis_pkg::ONE_Q16)
  `MIS_ASSERT_IMPL(a_out_in_range, out_vld_q, out_data_q.conf <= mis_pkg::ONE_Q16)
  `MIS_ASSERT_IMPL(a_score_while_wait, sc_rsp.vld, state_q == mis_pkg::ST_WAIT)
  `MIS_ASSERT_IMPL(a_blend_while_drain, bl_rsp.vld, state_q == mis_pkg::ST_DRAIN)
  `MIS_ASSERT_NEXT(a_take_loads_out, bl_take, out_vld_q && (state_q == mis_pkg::ST_IDLE))

endmodule

`default_nettype wire

// ===== rtl/mis_score_unit.sv =====
// per-feature score: threshold compare, then if between the thresholds a
// radix-2 restoring divider, one quotient bit per cycle; needs mis_pkg
`timescale 1ns / 1ps
`default_nettype none

module mis_score_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [mis_pkg::FEAT_W-1:0] value_i,
  input  wire mis_pkg::mis_thr_t                 thr_i,
  output mis_pkg::mis_score_rsp_t                rsp_o
);

  mis_pkg::mis_sc_state_e state_q, state_d;
  mis_pkg::mis_score_rsp_t rsp_q, rsp_d;

  logic signed [mis_pkg::DIFF_W-1:0] diff_q, diff_d;
  logic signed [mis_pkg::DIFF_W-1:0] span_q, span_d;
  logic degen_q, degen_d;
  logic ge_q, ge_d;
  logic [mis_pkg::SPAN_W-1:0] rem_q, rem_d;
  logic [mis_pkg::QUO_W-1:0]  quo_q, quo_d;
  logic [mis_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  logic [mis_pkg::SPAN_W:0] rem_sh;
  logic [mis_pkg::SPAN_W:0] span_ext;
  logic [mis_pkg::SPAN_W:0] rem_nx;
  logic                     fits;

  // one restoring step: shift remainder, subtract span if it fits
  always_comb begin
    rem_sh   = {rem_q, 1'b0};
    span_ext = {1'b0, span_q[mis_pkg::SPAN_W-1:0]};
    fits     = (rem_sh >= span_ext);
    rem_nx   = fits ? (rem_sh - span_ext) : rem_sh;
  end

  always_comb begin
    state_d = state_q;
    rsp_d   = '{vld: 1'b0, score: rsp_q.score};
    diff_d  = diff_q;
    span_d  = span_q;
    degen_d = degen_q;
    ge_d    = ge_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      mis_pkg::SC_IDLE: begin
        if (start_i) begin
          diff_d  = {value_i[mis_pkg::FEAT_W-1], value_i}
                  - {thr_i.low[mis_pkg::FEAT_W-1], thr_i.low};
          span_d  = {thr_i.high[mis_pkg::FEAT_W-1], thr_i.high}
                  - {thr_i.low[mis_pkg::FEAT_W-1], thr_i.low};
          degen_d = (thr_i.high <= thr_i.low);
          ge_d    = (value_i >= thr_i.high);
          state_d = mis_pkg::SC_PREP;
        end
      end
      mis_pkg::SC_PREP: begin
        priority if (degen_q) begin
          rsp_d   = '{vld: 1'b1, score: (ge_q ? mis_pkg::ONE_Q16 : '0)};
          state_d = mis_pkg::SC_IDLE;
        end else if (diff_q <= 25'sd0) begin
          rsp_d   = '{vld: 1'b1, score: '0};
          state_d = mis_pkg::SC_IDLE;
        end else if (diff_q >= span_q) begin
          rsp_d   = '{vld: 1'b1, score: mis_pkg::ONE_Q16};
          state_d = mis_pkg::SC_IDLE;
        end else begin
          // 0 < diff < span, so both fit the unsigned span width
          rem_d   = diff_q[mis_pkg::SPAN_W-1:0];
          quo_d   = '0;
          cnt_d   = '0;
          state_d = mis_pkg::SC_DIV;
        end
      end
      mis_pkg::SC_DIV: begin
        rem_d = rem_nx[mis_pkg::SPAN_W-1:0];
        quo_d = {quo_q[mis_pkg::QUO_W-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == mis_pkg::DIV_LAST) begin
          rsp_d   = '{vld: 1'b1, score: {1'b0, quo_q[mis_pkg::QUO_W-2:0], fits}};
          state_d = mis_pkg::SC_IDLE;
        end
      end
      default: begin
        state_d = mis_pkg::SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mis_pkg::SC_IDLE;
      rsp_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      rsp_q   <= rsp_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    span_q  <= span_d;
    degen_q <= degen_d;
    ge_q    <= ge_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/mis_blend.sv =====
// weighted sum of the four scores and exponential smoothing of the result
// holds the smoothed confidence state; depends on mis_pkg
`timescale 1ns / 1ps
`default_nettype none

module mis_blend (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  clear_i,
  input  wire mis_pkg::mis_score_rsp_t               score_i,
  input  wire logic [mis_pkg::FEAT_IDX_W-1:0]        sel_i,
  input  wire logic                                  take_i,
  output mis_pkg::mis_blend_rsp_t                    rsp_o
);

  logic [mis_pkg::PROD_W-1:0]  prod_q;
  logic                        prod_vld_q, prod_last_q;
  logic [mis_pkg::ACC_W-1:0]   acc_q;
  logic                        acc_last_q;
  logic [mis_pkg::MIX_W-1:0]   mix_a_q, mix_b_q;
  logic [mis_pkg::SCORE_W-1:0] raw_q;
  logic                        seed_q;
  logic                        mix_vld_q;
  logic [mis_pkg::SCORE_W-1:0] smooth_q;
  logic                        res_vld_q;

  logic [mis_pkg::SCORE_W-1:0] raw_w;
  logic [mis_pkg::MIX_W-1:0]   mix_sum;
  logic [mis_pkg::SCORE_W:0]   mix_div;
  logic [mis_pkg::SCORE_W-1:0] mix_w;
  logic [mis_pkg::SCORE_W-1:0] next_w;

  always_comb begin
    raw_w = acc_q[mis_pkg::ACC_W-1:mis_pkg::QUO_W];
    if (raw_w > mis_pkg::ONE_Q16) begin
      raw_w = mis_pkg::ONE_Q16;
    end
    mix_sum = mix_a_q + mix_b_q;
    mix_div = mix_sum[mis_pkg::MIX_W-1:mis_pkg::QUO_W];
    mix_w   = (mix_div > {1'b0, mis_pkg::ONE_Q16}) ? mis_pkg::ONE_Q16
                                                   : mix_div[mis_pkg::SCORE_W-1:0];
    next_w  = seed_q ? raw_q : mix_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q  <= 1'b0;
      prod_last_q <= 1'b0;
      acc_last_q  <= 1'b0;
      mix_vld_q   <= 1'b0;
      res_vld_q   <= 1'b0;
      smooth_q    <= '0;
      acc_q       <= '0;
    end else begin
      prod_vld_q  <= score_i.vld;
      prod_last_q <= score_i.vld && (sel_i == mis_pkg::FEAT_LAST);
      acc_last_q  <= prod_vld_q && prod_last_q;
      mix_vld_q   <= acc_last_q;
      if (clear_i) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + {1'b0, prod_q};
      end
      if (mix_vld_q) begin
        smooth_q  <= next_w;
        res_vld_q <= 1'b1;
      end else if (take_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (score_i.vld) begin
      prod_q <= mis_pkg::PROD_W'(mis_pkg::weight(sel_i)) * mis_pkg::PROD_W'(score_i.score);
    end
    if (acc_last_q) begin
      mix_a_q <= mis_pkg::MIX_W'(mis_pkg::KEEP) * mis_pkg::MIX_W'(smooth_q);
      mix_b_q <= mis_pkg::MIX_W'(mis_pkg::ALPHA) * mis_pkg::MIX_W'(raw_w);
      raw_q   <= raw_w;
      // first nonzero raw value seeds an empty average
      seed_q  <= (smooth_q == '0) && (raw_w != '0);
    end
  end

  assign rsp_o = '{vld: res_vld_q, conf: smooth_q};

endmodule

`default_nettype wire
